// File: sv/irsp_pkg.sv
// Shared types and constants for the report stream parser.
`default_nettype none

package irsp_pkg;

  // Report framing
  localparam logic [7:0] LEN_DIGITAL      = 8'd2;
  localparam logic [7:0] LEN_ANALOG       = 8'd3;
  localparam logic [7:0] FIRST_DIGITAL_ID = 8'h01;
  localparam logic [7:0] ANALOG_FIRST_ID  = 8'd9;
  localparam logic [7:0] ANALOG_LAST_ID   = 8'd96;

  // Sizing defaults
  localparam int MAX_GROUPS     = 8;
  localparam int DIGITAL_GROUPS = 8;
  localparam int QUEUE_DEPTH    = 4;

  // Event kinds
  localparam logic KIND_DIGITAL = 1'b0;
  localparam logic KIND_ANALOG  = 1'b1;

  // One classified report waiting to be expanded into events
  typedef struct packed {
    logic        kind;   // digital change group or analog reading
    logic [6:0]  chan;   // analog channel, or first channel of the group
    logic [15:0] level;  // analog value, or new group byte in the low half
    logic [7:0]  mask;   // changed bits of a digital group
  } job_t;

endpackage

`default_nettype wire

// File: sv/irsp_front.sv
// Front end: parses the byte stream, tracks digital history, emits jobs.
`default_nettype none

module irsp_front #(
  parameter int DIGITAL_GROUPS = irsp_pkg::DIGITAL_GROUPS
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    stream_byte,
  input  wire logic          queue_full,
  output logic               push,
  output irsp_pkg::job_t     push_job
);

  localparam int GW = (DIGITAL_GROUPS > 1) ? $clog2(DIGITAL_GROUPS) : 1;

  typedef enum logic [1:0] {
    POS_LENGTH,
    POS_ID,
    POS_DATA_LO,
    POS_DATA_HI
  } pos_t;

  pos_t        pos;
  logic        is_three;
  logic [7:0]  skip;
  logic [7:0]  rec_id;
  logic [7:0]  low_byte;
  logic [7:0]  history [DIGITAL_GROUPS];

  logic          accept;
  logic          id_digital;
  logic          id_analog;
  logic [GW-1:0] group;
  logic [7:0]    diff;

  // Accept a byte whenever the job queue has room
  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  // Classify the current report id
  assign id_digital = (rec_id >= irsp_pkg::FIRST_DIGITAL_ID) &&
                      (rec_id <= 8'(DIGITAL_GROUPS));
  assign id_analog  = (rec_id >= irsp_pkg::ANALOG_FIRST_ID) &&
                      (rec_id <= irsp_pkg::ANALOG_LAST_ID);
  assign group      = GW'(rec_id - 8'd1);
  assign diff       = id_digital ? (stream_byte ^ history[group]) : 8'd0;

  // Build the job for a finished report
  always_comb begin
    push     = 1'b0;
    push_job = '0;
    if (pos == POS_DATA_LO) begin
      push_job.kind  = irsp_pkg::KIND_DIGITAL;
      push_job.chan  = 7'((rec_id - 8'd1) << 3);
      push_job.level = {8'd0, stream_byte};
      push_job.mask  = diff;
      push           = accept && !is_three && id_digital && (diff != 8'd0);
    end else if (pos == POS_DATA_HI) begin
      push_job.kind  = irsp_pkg::KIND_ANALOG;
      push_job.chan  = 7'(rec_id - irsp_pkg::ANALOG_FIRST_ID);
      push_job.level = {stream_byte, low_byte};
      push_job.mask  = 8'd0;
      push           = accept && id_analog;
    end
  end

  // Advance the parse position and update history
  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= POS_LENGTH;
      is_three <= 1'b0;
      skip     <= 8'd0;
      rec_id   <= 8'd0;
      low_byte <= 8'd0;
      for (int g = 0; g < DIGITAL_GROUPS; g++) begin
        history[g] <= 8'd0;
      end
    end else if (accept) begin
      case (pos)
        POS_LENGTH: begin
          if (skip != 8'd0) begin
            skip <= skip - 8'd1;
          end else if (stream_byte == irsp_pkg::LEN_DIGITAL ||
                       stream_byte == irsp_pkg::LEN_ANALOG) begin
            is_three <= (stream_byte == irsp_pkg::LEN_ANALOG);
            pos      <= POS_ID;
          end else begin
            skip <= stream_byte;
          end
        end
        POS_ID: begin
          rec_id <= stream_byte;
          pos    <= POS_DATA_LO;
        end
        POS_DATA_LO: begin
          if (is_three) begin
            low_byte <= stream_byte;
            pos      <= POS_DATA_HI;
          end else begin
            pos <= POS_LENGTH;
            if (id_digital) begin
              history[group] <= stream_byte;
            end
          end
        end
        POS_DATA_HI: begin
          pos <= POS_LENGTH;
        end
        default: begin
          pos <= POS_LENGTH;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/irsp_queue.sv
// Job queue between the parser front end and the event back end.
`default_nettype none

module irsp_queue #(
  parameter int DEPTH = irsp_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire irsp_pkg::job_t push_job,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output irsp_pkg::job_t      head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  irsp_pkg::job_t   entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue occupancy beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push || pop)
    else $error("transfer pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from an empty queue");

endmodule

`default_nettype wire

// File: sv/irsp_back.sv
// Back end: expands queued jobs into events, one per cycle while the output is not stalled.
`default_nettype none

module irsp_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           job_valid,
  input  wire irsp_pkg::job_t job,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic                event_kind,
  output logic [6:0]          channel,
  output logic [15:0]         level,
  output logic                last
);

  irsp_pkg::job_t cur;
  logic           cur_valid;
  logic [7:0]     cur_mask;

  logic           emit;
  logic           emit_last;
  logic [2:0]     bit_idx;
  logic [7:0]     mask_next;

  // Pick the lowest pending changed bit
  always_comb begin
    bit_idx = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (cur_mask[b]) begin
        bit_idx = 3'(b);
      end
    end
  end

  assign mask_next = cur_mask & (cur_mask - 8'd1);
  assign emit      = cur_valid && (!out_valid || out_ready);
  assign emit_last = (cur.kind == irsp_pkg::KIND_ANALOG) || (mask_next == 8'd0);
  assign pop       = job_valid && (!cur_valid || (emit && emit_last));

  // Hold the current job and drive the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cur_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid  <= 1'b1;
        event_kind <= cur.kind;
        last       <= emit_last;
        if (cur.kind == irsp_pkg::KIND_ANALOG) begin
          channel <= cur.chan;
          level   <= cur.level;
        end else begin
          channel <= cur.chan + {4'd0, bit_idx};
          level   <= {15'd0, cur.level[bit_idx]};
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (pop) begin
        cur       <= job;
        cur_mask  <= job.mask;
        cur_valid <= 1'b1;
      end else if (emit && emit_last) begin
        cur_valid <= 1'b0;
      end else if (emit) begin
        cur_mask <= mask_next;
      end
    end
  end

  a_digital_pending: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && cur.kind == irsp_pkg::KIND_DIGITAL) |-> cur_mask != 8'd0)
    else $error("digital job in progress with no changed bit");

  a_analog_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind == irsp_pkg::KIND_ANALOG) |-> last)
    else $error("analog event not marked last");

  a_digital_level: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind == irsp_pkg::KIND_DIGITAL) |->
      (level[15:1] == 15'd0 && channel < 7'd64))
    else $error("digital event out of range");

endmodule

`default_nettype wire

// File: sv/io_report_stream_parser.sv
// Top level of the report stream parser: front end, job queue, back end.
//
//   channel | signals                                                | direction
//   --------+--------------------------------------------------------+----------
//   in      | in_valid, in_ready, stream_byte                        | sink
//   out     | out_valid, out_ready, event_kind, channel, level, last | source
//
// One byte is taken per cycle while the job queue has room.
// An analog report with an id in range yields one event; a digital one yields one
// event per changed bit, lowest first, one per cycle while the output is not stalled.
// The back end loads a new event in the cycle the previous one transfers.
// Reset clears the parse state, the digital history and the queue at once.
// A stalled output fills the queue, and then in_ready drops.
`default_nettype none

module io_report_stream_parser #(
  parameter int DIGITAL_GROUPS = irsp_pkg::DIGITAL_GROUPS,
  parameter int QUEUE_DEPTH    = irsp_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  stream_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             event_kind,
  output logic [6:0]       channel,
  output logic [15:0]      level,
  output logic             last
);

  logic           queue_full;
  logic           push;
  irsp_pkg::job_t push_job;
  logic           pop;
  logic           job_valid;
  irsp_pkg::job_t head;

  // Parse and classify
  irsp_front #(
    .DIGITAL_GROUPS (DIGITAL_GROUPS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .stream_byte (stream_byte),
    .queue_full  (queue_full),
    .push        (push),
    .push_job    (push_job)
  );

  // Decouple front and back
  irsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (job_valid),
    .head      (head)
  );

  // Expand jobs into events
  irsp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (job_valid),
    .job        (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_kind (event_kind),
    .channel    (channel),
    .level      (level),
    .last       (last)
  );

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the report stream parser (digital change and analog events).
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_REPORTS = 10;

  typedef enum logic [1:0] {
    P_LEN,
    P_ID,
    P_DATA0,
    P_DATA1
  } parse_pos_t;

  typedef struct packed {
    logic        kind;
    logic [6:0]  chan;
    logic [15:0] level;
    logic        last;
  } event_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  stream_byte;
  logic        out_valid;
  logic        out_ready;
  logic        event_kind;
  logic [6:0]  channel;
  logic [15:0] level;
  logic        last;

  // Predicted parser state
  logic [7:0]  hist_bytes [8];
  parse_pos_t  parse_pos;
  logic [7:0]  rep_len;
  logic [7:0]  skip_left;
  logic [7:0]  rep_id;
  logic [7:0]  low_byte;

  event_t      exp_events [$];
  event_t      got_event;
  event_t      want_event;

  bit          idle_on;
  int          hold_req;
  int          hold_left;
  int          stall_left;
  int          errors;
  int          cycle_count;
  int          bytes_sent;
  int          dig_seen;
  int          ana_seen;
  int          in_stall_cycles;

  io_report_stream_parser uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .stream_byte (stream_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_kind  (event_kind),
    .channel     (channel),
    .level       (level),
    .last        (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones; none while idling is off
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Advance the predicted parser by one byte and queue the events it causes
  function automatic void predict_byte(input logic [7:0] b);
    event_t     ev;
    logic [7:0] diff;
    int         grp;
    int         top;
    case (parse_pos)
      P_LEN: begin
        if (skip_left != 8'd0) begin
          skip_left = skip_left - 8'd1;
        end else if (b == irsp_pkg::LEN_DIGITAL || b == irsp_pkg::LEN_ANALOG) begin
          rep_len   = b;
          parse_pos = P_ID;
        end else begin
          skip_left = b;
        end
      end
      P_ID: begin
        rep_id    = b;
        parse_pos = P_DATA0;
      end
      P_DATA0: begin
        if (rep_len == irsp_pkg::LEN_ANALOG) begin
          low_byte  = b;
          parse_pos = P_DATA1;
        end else begin
          parse_pos = P_LEN;
          if (rep_id >= irsp_pkg::FIRST_DIGITAL_ID &&
              rep_id <= irsp_pkg::DIGITAL_GROUPS) begin
            grp  = rep_id - 1;
            diff = b ^ hist_bytes[grp];
            top  = -1;
            for (int i = 0; i < 8; i++) if (diff[i]) top = i;
            // one event per changed bit, lowest first
            for (int i = 0; i < 8; i++) begin
              if (diff[i]) begin
                ev.kind  = irsp_pkg::KIND_DIGITAL;
                ev.chan  = 7'(grp * 8 + i);
                ev.level = {15'd0, b[i]};
                ev.last  = (i == top);
                exp_events.push_back(ev);
              end
            end
            hist_bytes[grp] = b;
          end
        end
      end
      P_DATA1: begin
        parse_pos = P_LEN;
        if (rep_id >= irsp_pkg::ANALOG_FIRST_ID && rep_id <= irsp_pkg::ANALOG_LAST_ID) begin
          ev.kind  = irsp_pkg::KIND_ANALOG;
          ev.chan  = 7'(rep_id - irsp_pkg::ANALOG_FIRST_ID);
          ev.level = {b, low_byte};
          ev.last  = 1'b1;
          exp_events.push_back(ev);
        end
      end
      default: begin
        parse_pos = P_LEN;
      end
    endcase
  endfunction

  // Offer one byte, hold it until the transfer, then predict
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    stream_byte <= b;
    do @(posedge clk); while (!in_ready);
    predict_byte(b);
    bytes_sent++;
  endtask

  task automatic send_digital(input logic [7:0] id, input logic [7:0] data);
    send_byte(irsp_pkg::LEN_DIGITAL);
    send_byte(id);
    send_byte(data);
  endtask

  task automatic send_analog(input logic [7:0] id, input logic [15:0] value);
    send_byte(irsp_pkg::LEN_ANALOG);
    send_byte(id);
    send_byte(value[7:0]);
    send_byte(value[15:8]);
  endtask

  // Stop offering and wait until every expected event has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (exp_events.size() != 0);
  endtask

  task automatic test_digital_reports();
    send_digital(8'd1, 8'hFF);   // all bits rise in group 0
    send_digital(8'd1, 8'hFF);   // unchanged group
    send_digital(8'd8, 8'h5A);   // highest group
    send_digital(8'd0, 8'hFF);   // id below range
    drain();
  endtask

  task automatic test_analog_reports();
    send_analog(irsp_pkg::ANALOG_FIRST_ID, 16'hFFFF);
    send_analog(irsp_pkg::ANALOG_LAST_ID, 16'h8001);
    drain();
  endtask

  task automatic test_skipped_reports();
    send_byte(8'd0);             // empty report
    send_byte(8'd1);             // one-byte report hiding a length value
    send_byte(irsp_pkg::LEN_ANALOG);
    send_byte(8'd4);             // four-byte report that looks like an analog one
    send_byte(irsp_pkg::LEN_ANALOG);
    send_byte(irsp_pkg::ANALOG_FIRST_ID);
    send_byte(8'h00);
    send_byte(8'h00);
    drain();
  endtask

  // Mostly well-formed reports with random content, the rest noise
  task automatic send_random_report();
    int         r;
    int         len;
    logic [7:0] id;
    logic [7:0] data;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      if ($urandom_range(0, 9) != 0) id = 8'($urandom_range(1, irsp_pkg::DIGITAL_GROUPS));
      else if ($urandom_range(0, 1) != 0) id = 8'd0;
      else id = 8'($urandom_range(irsp_pkg::ANALOG_FIRST_ID, 255));
      data = 8'($urandom_range(0, 255));
      if (id >= irsp_pkg::FIRST_DIGITAL_ID && id <= irsp_pkg::DIGITAL_GROUPS) begin
        r = $urandom_range(0, 99);
        if (r < 20) data = hist_bytes[id - 1];
        else if (r < 45) data = ~hist_bytes[id - 1];
      end
      send_digital(id, data);
    end else if (r < 85) begin
      if ($urandom_range(0, 9) != 0) begin
        id = 8'($urandom_range(irsp_pkg::ANALOG_FIRST_ID, irsp_pkg::ANALOG_LAST_ID));
      end else if ($urandom_range(0, 1) != 0) begin
        id = 8'($urandom_range(0, irsp_pkg::ANALOG_FIRST_ID - 1));
      end else begin
        id = 8'($urandom_range(irsp_pkg::ANALOG_LAST_ID + 1, 255));
      end
      send_analog(id, 16'($urandom_range(0, 65535)));
    end else begin
      r = $urandom_range(0, 9);
      if (r < 2) len = r;
      else len = $urandom_range(4, 12);
      send_byte(8'(len));
      repeat (len) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_stream(input int n_bytes, input bit idle);
    int target;
    idle_on = idle;
    target  = bytes_sent + n_bytes;
    while (bytes_sent < target) send_random_report();
    drain();
  endtask

  // Stall the output for a long stretch while digital reports keep coming
  task automatic test_output_backpressure();
    logic [7:0] id;
    idle_on  = 1'b0;
    hold_req = 400;
    for (int k = 0; k < 12; k++) begin
      id = 8'(k % irsp_pkg::DIGITAL_GROUPS + 1);
      send_digital(id, ~hist_bytes[id - 1]);
    end
    drain();
    idle_on = 1'b1;
  endtask

  // Skip a maximum-length report, then prove the parser is back in step
  task automatic test_long_skip();
    send_byte(8'hFF);
    repeat (255) send_byte(8'($urandom_range(0, 255)));
    send_digital(8'd1, ~hist_bytes[0]);
    drain();
  endtask

  // Drive the output ready with random stalls and the long hold-off
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
      out_ready <= (stall_left == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each transfer on the output with the oldest expected event
  always @(posedge clk) begin
    if (!rst && in_valid && !in_ready) in_stall_cycles++;
    if (!rst && out_valid && out_ready) begin
      got_event = '{event_kind, channel, level, last};
      if (event_kind == irsp_pkg::KIND_ANALOG) ana_seen++;
      else dig_seen++;
      if (exp_events.size() == 0) begin
        note_error($sformatf("unexpected event: kind %0d chan %0d level %h last %0d",
                             event_kind, channel, level, last));
      end else begin
        want_event = exp_events.pop_front();
        if (got_event.kind !== want_event.kind || got_event.chan !== want_event.chan ||
            got_event.level !== want_event.level || got_event.last !== want_event.last) begin
          note_error($sformatf(
            "event mismatch: exp kind %0d chan %0d level %h last %0d, got %0d %0d %h %0d",
            want_event.kind, want_event.chan, want_event.level, want_event.last,
            got_event.kind, got_event.chan, got_event.level, got_event.last));
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    stream_byte <= 8'd0;
    out_ready   <= 1'b0;
    idle_on      = 1'b1;
    hold_req     = 0;
    hold_left    = 0;
    stall_left   = 0;
    errors       = 0;
    cycle_count  = 0;
    bytes_sent   = 0;
    dig_seen     = 0;
    ana_seen     = 0;
    in_stall_cycles = 0;
    for (int g = 0; g < 8; g++) hist_bytes[g] = 8'd0;
    parse_pos = P_LEN;
    rep_len   = 8'd0;
    skip_left = 8'd0;
    rep_id    = 8'd0;
    low_byte  = 8'd0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_digital_reports();
    test_analog_reports();
    test_skipped_reports();
    test_random_stream(50, 1'b1);
    test_random_stream(30, 1'b0);
    test_output_backpressure();
    test_long_skip();
    test_random_stream(30, 1'b1);

    repeat (20) @(posedge clk);
    errors += exp_events.size();
    $display("Sent %0d stream bytes; checked %0d digital and %0d analog events",
             bytes_sent, dig_seen, ana_seen);
    $display("Input held off for %0d cycles by output back-pressure", in_stall_cycles);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
